// File: hdl/esms_pkg.sv
package esms_pkg;

  // Request kinds carried in the input tuser
  localparam logic [2:0] MODE_RUN  = 3'd0;
  localparam logic [2:0] MODE_UP   = 3'd1;
  localparam logic [2:0] MODE_DOWN = 3'd2;
  localparam logic [2:0] MODE_STOP = 3'd3;
  localparam logic [2:0] MODE_POS  = 3'd4;
  localparam logic [2:0] MODE_INIT = 3'd5;

  // Motor commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;
  localparam logic [1:0] CMD_ZERO = 2'd3;

  // Control states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_UP      = 4'd1;
  localparam logic [3:0] ST_DW      = 4'd2;
  localparam logic [3:0] ST_POS     = 4'd3;
  localparam logic [3:0] ST_FAIL    = 4'd4;
  localparam logic [3:0] ST_CAL_TOP = 4'd5;
  localparam logic [3:0] ST_CAL_BOT = 4'd6;
  localparam logic [3:0] ST_CAL_UN  = 4'd7;
  localparam logic [3:0] ST_CAL_FIN = 4'd8;

  // Directions
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [1:0] DIR_REV  = 2'sb11;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_VALID  = 2'd0;
  localparam logic [1:0] REG_UP_DIR = 2'd1;
  localparam logic [1:0] REG_TRAVEL = 2'd2;

  // Timing and speed constants
  localparam logic [31:0] SAFETY_MS    = 32'd20000;
  localparam logic [31:0] REVERSE_MS   = 32'd2000;
  localparam logic [31:0] UNWIND_MS    = 32'd500;
  localparam logic [31:0] TOP_PROBE_MS = 32'd200;
  localparam logic [7:0]  DEFAULT_RPM  = 8'd8;
  localparam logic [7:0]  SLOW_RPM     = 8'd2;

  // Travel time scale 110/100 and the first elapsed time that saturates
  localparam int unsigned SCALE_NUM  = 110;
  localparam int unsigned SCALE_DEN  = 100;
  localparam int unsigned TRAVEL_SAT = (65536 * SCALE_DEN + SCALE_NUM - 1) / SCALE_NUM;
  // Reciprocal of ten, exact for any 16-bit dividend
  localparam logic [15:0] RECIP_TEN  = 16'hCCCD;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic              valid;
    logic signed [1:0] up_dir;
    logic [15:0]       travel_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [31:0]       now_ms;
    logic              top_hit;
    logic              bottom_hit;
    logic signed [1:0] motor_moving_dir;
    logic [15:0]       motor_position;
    logic [15:0]       target_position;
    logic [7:0]        speed_request;
  } item_t;

  typedef struct packed {
    logic [1:0]        motor_cmd;
    logic signed [1:0] move_dir;
    logic [7:0]        move_speed;
    logic [15:0]       move_steps;
    logic              save_calib;
    logic [15:0]       saved_travel_ms;
    logic signed [1:0] saved_up_dir;
    logic [3:0]        control_state;
  } result_t;

  // A direction code of -2 counts as -1
  function automatic logic signed [1:0] norm_dir(input logic [1:0] d);
    norm_dir = (d == 2'b10) ? DIR_REV : $signed(d);
  endfunction

  function automatic logic signed [1:0] neg_dir(input logic signed [1:0] d);
    logic signed [1:0] n;
    n = norm_dir(d);
    if (n == DIR_FWD) begin
      neg_dir = DIR_REV;
    end else if (n == DIR_REV) begin
      neg_dir = DIR_FWD;
    end else begin
      neg_dir = DIR_NONE;
    end
  endfunction

endpackage

// File: hdl/esms_apb.sv
module esms_apb (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output esms_pkg::cfg_t     cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        esms_pkg::REG_VALID:  cfg.valid     <= pwdata[0];
        esms_pkg::REG_UP_DIR: cfg.up_dir    <= esms_pkg::norm_dir(pwdata[1:0]);
        esms_pkg::REG_TRAVEL: cfg.travel_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      esms_pkg::REG_VALID:  prdata = {31'd0, cfg.valid};
      esms_pkg::REG_UP_DIR: prdata = {30'd0, cfg.up_dir};
      esms_pkg::REG_TRAVEL: prdata = {16'd0, cfg.travel_ms};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// File: hdl/esms_ctrl.sv
module esms_ctrl #(
  parameter int POS_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  esms_pkg::item_t     item,
  input  esms_pkg::cfg_t      cfg,
  output esms_pkg::result_t   res
);

  localparam logic [15:0] POS_MASK =
    (POS_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << POS_BITS) - 32'd1);

  logic [3:0]        ctrl_state, ctrl_state_next;
  logic              deadline_armed, deadline_armed_next;
  logic [31:0]       deadline_ms, deadline_ms_next;
  logic [31:0]       calib_start_ms, calib_start_ms_next;
  logic signed [1:0] up_direction, up_direction_next;
  logic signed [1:0] down_direction, down_direction_next;
  logic [15:0]       travel_time_ms, travel_time_ms_next;

  logic              arm_en;
  logic [31:0]       arm_offset;
  logic [31:0]       arm_ms;

  logic signed [1:0] mdir;
  logic signed [1:0] mdir_neg;
  logic [7:0]        speed;
  logic [15:0]       cpos;
  logic [15:0]       tpos;
  logic              busy_locked;
  logic              expired;

  logic [31:0]       elapsed;
  logic [15:0]       elapsed_lo;
  logic [31:0]       tenth_prod;
  logic [15:0]       scaled;

  assign mdir        = esms_pkg::norm_dir(item.motor_moving_dir);
  assign mdir_neg    = esms_pkg::neg_dir(mdir);
  assign speed       = (item.speed_request == 8'd0) ? esms_pkg::DEFAULT_RPM
                                                    : item.speed_request;
  assign cpos        = item.motor_position & POS_MASK;
  assign tpos        = item.target_position & POS_MASK;
  assign busy_locked = ctrl_state >= esms_pkg::ST_FAIL;
  assign expired     = deadline_armed && (item.now_ms >= deadline_ms);
  assign arm_ms      = item.now_ms + arm_offset;

  // Elapsed * 1.1 computed as x + x/10, saturated
  assign elapsed    = item.now_ms - calib_start_ms;
  assign elapsed_lo = elapsed[15:0];
  assign tenth_prod = elapsed_lo * esms_pkg::RECIP_TEN;
  assign scaled     = (elapsed >= 32'(esms_pkg::TRAVEL_SAT)) ? 16'hFFFF :
                      elapsed_lo + 16'(tenth_prod[31:esms_pkg::RECIP_SHIFT]);

  always_comb begin
    ctrl_state_next     = ctrl_state;
    deadline_armed_next = deadline_armed;
    calib_start_ms_next = calib_start_ms;
    up_direction_next   = up_direction;
    down_direction_next = down_direction;
    travel_time_ms_next = travel_time_ms;
    arm_en              = 1'b0;
    arm_offset          = esms_pkg::SAFETY_MS;
    res                 = '0;

    case (item.mode)
      esms_pkg::MODE_RUN: begin
        if (ctrl_state == esms_pkg::ST_IDLE) begin
          deadline_armed_next = 1'b0;
        end else if (expired) begin
          if (ctrl_state == esms_pkg::ST_CAL_TOP && mdir == esms_pkg::DIR_FWD) begin
            res.motor_cmd  = esms_pkg::CMD_MOVE;
            res.move_dir   = esms_pkg::DIR_REV;
            res.move_speed = esms_pkg::SLOW_RPM;
            arm_en         = 1'b1;
            arm_offset     = esms_pkg::REVERSE_MS;
          end else begin
            res.motor_cmd       = esms_pkg::CMD_STOP;
            ctrl_state_next     = esms_pkg::ST_FAIL;
            deadline_armed_next = 1'b0;
          end
        end else begin
          unique case (ctrl_state)
            esms_pkg::ST_CAL_TOP: begin
              if (!item.top_hit) begin
                res.motor_cmd   = esms_pkg::CMD_MOVE;
                res.move_dir    = mdir_neg;
                res.move_speed  = esms_pkg::DEFAULT_RPM;
                ctrl_state_next = esms_pkg::ST_CAL_UN;
                arm_en          = 1'b1;
                arm_offset      = esms_pkg::UNWIND_MS;
              end
            end
            esms_pkg::ST_CAL_BOT: begin
              if (!item.bottom_hit) begin
                ctrl_state_next = esms_pkg::ST_CAL_UN;
                arm_en          = 1'b1;
              end
            end
            esms_pkg::ST_CAL_UN: begin
              if (item.bottom_hit) begin
                res.motor_cmd   = esms_pkg::CMD_MOVE;
                res.move_dir    = mdir_neg;
                res.move_speed  = esms_pkg::DEFAULT_RPM;
                ctrl_state_next = esms_pkg::ST_CAL_BOT;
                arm_en          = 1'b1;
              end else if (item.top_hit) begin
                up_direction_next   = mdir;
                down_direction_next = mdir_neg;
                ctrl_state_next     = esms_pkg::ST_CAL_FIN;
                arm_en              = 1'b1;
                calib_start_ms_next = item.now_ms;
                res.motor_cmd       = esms_pkg::CMD_MOVE;
                res.move_dir        = mdir_neg;
                res.move_speed      = esms_pkg::DEFAULT_RPM;
              end
            end
            esms_pkg::ST_CAL_FIN: begin
              if (item.bottom_hit) begin
                travel_time_ms_next = scaled;
                res.save_calib      = 1'b1;
                res.saved_travel_ms = scaled;
                res.saved_up_dir    = up_direction;
                ctrl_state_next     = esms_pkg::ST_IDLE;
                res.motor_cmd       = esms_pkg::CMD_ZERO;
              end
            end
            esms_pkg::ST_UP: begin
              if (item.top_hit) begin
                ctrl_state_next = esms_pkg::ST_IDLE;
                res.motor_cmd   = esms_pkg::CMD_STOP;
              end
            end
            esms_pkg::ST_DW: begin
              if (item.bottom_hit) begin
                ctrl_state_next = esms_pkg::ST_IDLE;
                res.motor_cmd   = esms_pkg::CMD_ZERO;
              end
            end
            esms_pkg::ST_POS: begin
              if (mdir == esms_pkg::DIR_NONE) begin
                ctrl_state_next = esms_pkg::ST_IDLE;
                res.motor_cmd   = esms_pkg::CMD_STOP;
              end
            end
            default: begin
              deadline_armed_next = 1'b0;
              ctrl_state_next     = esms_pkg::ST_IDLE;
              res.motor_cmd       = esms_pkg::CMD_STOP;
            end
          endcase
        end
      end
      esms_pkg::MODE_UP: begin
        if (!busy_locked && !item.top_hit) begin
          ctrl_state_next = esms_pkg::ST_UP;
          arm_en          = 1'b1;
          res.motor_cmd   = esms_pkg::CMD_MOVE;
          res.move_dir    = up_direction;
          res.move_speed  = speed;
        end
      end
      esms_pkg::MODE_DOWN: begin
        if (!busy_locked && !item.bottom_hit) begin
          ctrl_state_next = esms_pkg::ST_DW;
          arm_en          = 1'b1;
          res.motor_cmd   = esms_pkg::CMD_MOVE;
          res.move_dir    = down_direction;
          res.move_speed  = speed;
        end
      end
      esms_pkg::MODE_STOP: begin
        if (ctrl_state != esms_pkg::ST_IDLE) begin
          ctrl_state_next     = esms_pkg::ST_IDLE;
          deadline_armed_next = 1'b0;
        end
        res.motor_cmd = esms_pkg::CMD_STOP;
      end
      esms_pkg::MODE_POS: begin
        if (tpos > cpos) begin
          ctrl_state_next = esms_pkg::ST_POS;
          arm_en          = 1'b1;
          res.motor_cmd   = esms_pkg::CMD_MOVE;
          res.move_dir    = up_direction;
          res.move_speed  = speed;
          res.move_steps  = tpos - cpos;
        end else if (tpos < cpos) begin
          ctrl_state_next = esms_pkg::ST_POS;
          arm_en          = 1'b1;
          res.motor_cmd   = esms_pkg::CMD_MOVE;
          res.move_dir    = down_direction;
          res.move_speed  = speed;
          res.move_steps  = cpos - tpos;
        end
      end
      esms_pkg::MODE_INIT: begin
        up_direction_next   = cfg.up_dir;
        down_direction_next = esms_pkg::neg_dir(cfg.up_dir);
        travel_time_ms_next = cfg.travel_ms;
        arm_en              = 1'b1;
        if (cfg.valid) begin
          arm_offset = {16'd0, cfg.travel_ms};
          if (!busy_locked && !item.bottom_hit) begin
            ctrl_state_next = esms_pkg::ST_DW;
            res.motor_cmd   = esms_pkg::CMD_MOVE;
            res.move_dir    = esms_pkg::neg_dir(cfg.up_dir);
            res.move_speed  = esms_pkg::DEFAULT_RPM;
          end
        end else if (item.top_hit) begin
          ctrl_state_next = esms_pkg::ST_CAL_TOP;
          arm_offset      = esms_pkg::TOP_PROBE_MS;
          res.motor_cmd   = esms_pkg::CMD_MOVE;
          res.move_dir    = esms_pkg::DIR_FWD;
          res.move_speed  = esms_pkg::SLOW_RPM;
        end else begin
          ctrl_state_next = item.bottom_hit ? esms_pkg::ST_CAL_BOT : esms_pkg::ST_CAL_UN;
          res.motor_cmd   = esms_pkg::CMD_MOVE;
          res.move_dir    = esms_pkg::DIR_FWD;
          res.move_speed  = esms_pkg::DEFAULT_RPM;
        end
      end
      default: ;
    endcase

    if (arm_en) begin
      deadline_armed_next = 1'b1;
    end
    res.control_state = ctrl_state_next;
  end

  assign deadline_ms_next = arm_en ? arm_ms : deadline_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state     <= esms_pkg::ST_IDLE;
      deadline_armed <= 1'b0;
      deadline_ms    <= '0;
      calib_start_ms <= '0;
      up_direction   <= esms_pkg::DIR_NONE;
      down_direction <= esms_pkg::DIR_NONE;
      travel_time_ms <= '0;
    end else if (fire) begin
      ctrl_state     <= ctrl_state_next;
      deadline_armed <= deadline_armed_next;
      deadline_ms    <= deadline_ms_next;
      calib_start_ms <= calib_start_ms_next;
      up_direction   <= up_direction_next;
      down_direction <= down_direction_next;
      travel_time_ms <= travel_time_ms_next;
    end
  end

endmodule

// File: hdl/endstop_motion_sequencer_unit.sv
// A transfer passes the input register and then the result register.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: synchronous, active high; control state goes idle, the deadline is
// disarmed and all stored timing, direction and configuration clear to zero.
module endstop_motion_sequencer_unit #(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] now_ms, [32] top_hit, [33] bottom_hit, [35:34] motor_moving_dir,
  // [51:36] motor_position, [67:52] target_position, [75:68] speed_request
  input  logic [79:0] s_tdata,
  // [2:0] mode
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] motor_cmd, [3:2] move_dir, [11:4] move_speed, [27:12] move_steps,
  // [28] save_calib, [44:29] saved_travel_ms, [46:45] saved_up_dir,
  // [50:47] control_state
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  esms_pkg::cfg_t    cfg;
  esms_pkg::item_t   item;
  esms_pkg::result_t res;
  logic              item_valid;
  logic              advance;
  logic              fire;

  esms_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !item_valid || advance;
  assign fire     = item_valid && advance;

  // Hold the accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.mode             <= s_tuser;
      item.now_ms           <= s_tdata[31:0];
      item.top_hit          <= s_tdata[32];
      item.bottom_hit       <= s_tdata[33];
      item.motor_moving_dir <= s_tdata[35:34];
      item.motor_position   <= s_tdata[51:36];
      item.target_position  <= s_tdata[67:52];
      item.speed_request    <= s_tdata[75:68];
    end
  end

  esms_ctrl #(
    .POS_BITS (POS_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {5'd0, res.control_state, res.saved_up_dir, res.saved_travel_ms,
                  res.save_calib, res.move_steps, res.move_speed, res.move_dir,
                  res.motor_cmd};
    end
  end

endmodule
